@@ hw/rtl/vbdr_pkg.sv @@
// Package for the video backlog drop/resync queue: field types, commands and constants.
package vbdr_pkg;

  // Fixed field widths of the command and result transactions
  localparam int ID_BITS    = 8;
  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 4;
  localparam int TALLY_BITS = 16;
  localparam int CFG_BITS   = 24;
  localparam int CFG_IDX_BITS = 2;

  // Commands
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_QUEUED      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BACKLOG_US  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_WAIT_DROPS = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_WAIT_US    = 2'd3;

  // Configuration reset values
  localparam logic [3:0]  MAX_QUEUED_RST      = 4'd8;
  localparam logic [23:0] MAX_BACKLOG_US_RST  = 24'd250000;
  localparam logic [3:0]  SYNC_WAIT_DROPS_RST = 4'd8;
  localparam logic [23:0] SYNC_WAIT_US_RST    = 24'd250000;

  // Counter limits
  localparam logic [TALLY_BITS-1:0] TALLY_MAX = 16'hFFFF;
  localparam logic [3:0]            WAIT_DROPS_MAX = 4'd15;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ID_BITS-1:0]   unit_id;
    logic [TIME_BITS-1:0] pts_us;
    logic                 has_idr;
    logic                 has_codec_config;
    logic [TIME_BITS-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  discarded;
    logic                  sync_mark;
    logic [COUNT_BITS-1:0] flushed_count;
    logic                  head_valid;
    logic [ID_BITS-1:0]    head_id;
    logic                  end_of_stream;
    logic                  in_sync_wait;
    logic [COUNT_BITS-1:0] level;
    logic [TALLY_BITS-1:0] drops_total;
  } result_t;

  // One queue slot: handle and timestamp
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] pts;
  } slot_t;

endpackage

@@ hw/rtl/vbdr_slots.sv @@
// Slot memory of the queue: one write port, one registered read port with write bypass.
module vbdr_slots #(
  parameter int DEPTH = 8,
  parameter int PTR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PTR_W-1:0]  wr_addr,
  input  vbdr_pkg::slot_t   wr_data,
  input  logic [PTR_W-1:0]  rd_addr,
  output vbdr_pkg::slot_t   rd_data
);

  vbdr_pkg::slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the address being read is forwarded
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/video_backlog_drop_resync.sv @@
// Top level: bounded queue of video unit handles with backlog flush and IDR resync.
// Latency: each command gives its result in the cycle after it is accepted, strobed by done.
// Throughput: one command per cycle; busy stays low, and state and the head-slot read
// register are updated at the same edge that registers the result.
// Reset (rst, synchronous): queue empty, not waiting, counters zero, not stopped,
// configuration back to its defaults. Results cannot be stalled by the receiver.
module video_backlog_drop_resync #(
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  vbdr_pkg::item_t                      item,
  output logic                                 done,
  output vbdr_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [vbdr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [vbdr_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TW    = vbdr_pkg::TIME_BITS;
  localparam int SUM_W = vbdr_pkg::TALLY_BITS + 2;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  // Configuration registers
  logic [3:0]  max_queued;
  logic [23:0] max_backlog_us;
  logic [3:0]  sync_wait_drops;
  logic [23:0] sync_wait_us;

  // Control state
  logic [PTR_W-1:0]              head_ptr, head_ptr_next;
  logic [CNT_W-1:0]              fill, fill_next;
  logic                          waiting, waiting_next;
  logic [3:0]                    wait_drops, wait_drops_next;
  logic [TW-1:0]                 wait_start, wait_start_next;
  logic [vbdr_pkg::TALLY_BITS-1:0] drop_tally, drop_tally_next;
  logic                          stopped, stopped_next;

  vbdr_pkg::result_t res_next;

  // Slot memory ports
  logic            wr_en;
  logic [PTR_W-1:0] wr_addr;
  vbdr_pkg::slot_t wr_data;
  vbdr_pkg::slot_t head_slot;

  // Enqueue decision terms
  logic             take;
  logic             fill_ge_limit;
  logic             too_long;
  logic             flush;
  logic             wait_eff;
  logic [CNT_W-1:0] fill_eff;
  logic [3:0]       wd_eff;
  logic [TW-1:0]    elapsed;
  logic             expired;
  logic             drop;
  logic [PTR_W:0]   tail_sum;
  logic [SUM_W-1:0] tally_sum;

  assign busy = 1'b0;
  assign take = start && !busy;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      max_queued      <= vbdr_pkg::MAX_QUEUED_RST;
      max_backlog_us  <= vbdr_pkg::MAX_BACKLOG_US_RST;
      sync_wait_drops <= vbdr_pkg::SYNC_WAIT_DROPS_RST;
      sync_wait_us    <= vbdr_pkg::SYNC_WAIT_US_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vbdr_pkg::REG_MAX_QUEUED:      max_queued      <= cfg_data[3:0];
        vbdr_pkg::REG_MAX_BACKLOG_US:  max_backlog_us  <= cfg_data;
        vbdr_pkg::REG_SYNC_WAIT_DROPS: sync_wait_drops <= cfg_data[3:0];
        vbdr_pkg::REG_SYNC_WAIT_US:    sync_wait_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Backlog check against the oldest queued unit
  always_comb begin
    fill_ge_limit = ({28'd0, max_queued} <= 32'(fill)) || (fill >= DEPTH_C);
    too_long = 1'b0;
    if ((fill != '0) && (item.pts_us != '0) && (head_slot.pts != '0) &&
        (item.pts_us > head_slot.pts)) begin
      too_long = (item.pts_us - head_slot.pts) > {{(TW-24){1'b0}}, max_backlog_us};
    end
    flush    = !stopped && !waiting && (fill_ge_limit || too_long);
    wait_eff = waiting || flush;
    fill_eff = flush ? '0 : fill;
    wd_eff   = flush ? 4'd0 : wait_drops;
    // Clock behind the wait start counts as no time elapsed
    if (flush || (item.now_us < wait_start)) begin
      elapsed = '0;
    end else begin
      elapsed = item.now_us - wait_start;
    end
    expired = (wd_eff >= sync_wait_drops) ||
              (elapsed >= {{(TW-24){1'b0}}, sync_wait_us});
    drop = wait_eff && !item.has_codec_config && !item.has_idr && !expired;
    tail_sum = {1'b0, head_ptr} + (PTR_W+1)'(fill_eff);
    if (tail_sum >= DEPTH_P) begin
      tail_sum = tail_sum - DEPTH_P;
    end
    tally_sum = SUM_W'(drop_tally) + (flush ? SUM_W'(fill) : '0) + SUM_W'(drop);
  end

  // Command execution
  always_comb begin
    head_ptr_next   = head_ptr;
    fill_next       = fill;
    waiting_next    = waiting;
    wait_drops_next = wait_drops;
    wait_start_next = wait_start;
    drop_tally_next = drop_tally;
    stopped_next    = stopped;
    res_next        = '0;
    wr_en           = 1'b0;
    wr_addr         = tail_sum[PTR_W-1:0];
    wr_data.id      = item.unit_id;
    wr_data.pts     = item.pts_us;

    if (take) begin
      case (item.cmd)
        vbdr_pkg::CMD_ENQUEUE: begin
          if (stopped) begin
            res_next.discarded = 1'b1;
          end else begin
            if (flush) begin
              res_next.flushed_count = vbdr_pkg::COUNT_BITS'(fill);
              wait_start_next = item.now_us;
            end
            fill_next       = fill_eff;
            waiting_next    = wait_eff;
            wait_drops_next = wd_eff;
            drop_tally_next = (tally_sum > SUM_W'(vbdr_pkg::TALLY_MAX)) ?
                              vbdr_pkg::TALLY_MAX : tally_sum[vbdr_pkg::TALLY_BITS-1:0];
            if (drop) begin
              res_next.discarded = 1'b1;
              if (wd_eff < vbdr_pkg::WAIT_DROPS_MAX) begin
                wait_drops_next = wd_eff + 4'd1;
              end
            end else if (fill_eff >= DEPTH_C) begin
              // Queue filled by config units: refuse with no further change
              res_next.discarded = 1'b1;
            end else begin
              wr_en              = 1'b1;
              fill_next          = fill_eff + CNT_W'(1);
              res_next.accepted  = 1'b1;
              res_next.sync_mark = item.has_idr ||
                                   (wait_eff && !item.has_codec_config);
              // Expired wait or an IDR both resynchronize
              if (wait_eff && (item.has_idr || !item.has_codec_config)) begin
                waiting_next    = 1'b0;
                wait_drops_next = 4'd0;
                drop_tally_next = '0;
              end
            end
          end
        end
        vbdr_pkg::CMD_DEQUEUE: begin
          if (stopped) begin
            res_next.end_of_stream = 1'b1;
          end else if (fill != '0) begin
            res_next.head_valid = 1'b1;
            res_next.head_id    = head_slot.id;
            head_ptr_next = (head_ptr == LAST_PTR) ? '0 : head_ptr + PTR_W'(1);
            fill_next     = fill - CNT_W'(1);
          end
        end
        vbdr_pkg::CMD_STOP: begin
          if (!stopped) begin
            stopped_next           = 1'b1;
            res_next.flushed_count = vbdr_pkg::COUNT_BITS'(fill);
            fill_next              = '0;
          end
        end
        default: ;
      endcase
    end

    res_next.in_sync_wait = waiting_next;
    res_next.level        = vbdr_pkg::COUNT_BITS'(fill_next);
    res_next.drops_total  = drop_tally_next;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      fill       <= '0;
      waiting    <= 1'b0;
      wait_drops <= 4'd0;
      wait_start <= '0;
      drop_tally <= '0;
      stopped    <= 1'b0;
      done       <= 1'b0;
    end else begin
      head_ptr   <= head_ptr_next;
      fill       <= fill_next;
      waiting    <= waiting_next;
      wait_drops <= wait_drops_next;
      wait_start <= wait_start_next;
      drop_tally <= drop_tally_next;
      stopped    <= stopped_next;
      done       <= take;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // Slot storage; the read register tracks the head slot
  vbdr_slots #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head_ptr_next),
    .rd_data (head_slot)
  );

endmodule

@@ verif/video_backlog_drop_resync_test.sv @@
// Testbench for the video backlog drop/resync queue: directed and random command traffic.
`timescale 1ns / 1ps

module video_backlog_drop_resync_test;
  import vbdr_pkg::*;

  localparam int QDEPTH = 8;
  localparam int STALL_LIMIT = 200;
  // Command code with no defined operation
  localparam logic [1:0] CMD_IDLE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  video_backlog_drop_resync #(.DEPTH(QDEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Mirror of the queue state and its registers
  logic [ID_BITS-1:0]   slot_id_mem [QDEPTH];
  logic [TIME_BITS-1:0] slot_pts_mem [QDEPTH];
  logic [2:0]           head_slot;
  logic [3:0]           fill_level;
  logic                 sync_waiting;
  logic [3:0]           wait_drop_cnt;
  logic [TIME_BITS-1:0] wait_since;
  logic [15:0]          drop_tally;
  logic                 stream_stopped;
  logic [3:0]           cfg_max_queued;
  logic [23:0]          cfg_max_backlog;
  logic [3:0]           cfg_sync_drops;
  logic [23:0]          cfg_sync_us;

  result_t step_reports[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;

  // Random stream shape, set per phase
  logic [TIME_BITS-1:0] stream_clock = 48'd1000000;
  int frame_step = 33333;
  int dequeue_pct = 40;
  int config_pct = 8;
  int idr_pct = 10;

  function automatic void bump_drop_tally(input int n);
    int sum;
    sum = drop_tally + n;
    drop_tally = (sum > TALLY_MAX) ? TALLY_MAX : sum[15:0];
  endfunction

  // One command against the mirrored queue; returns the status it reports
  function automatic result_t backlog_step(input item_t it);
    result_t r;
    logic [3:0] lim;
    logic too_long;
    logic mark;
    logic store;
    logic expired;
    logic [TIME_BITS-1:0] oldest;
    logic [TIME_BITS-1:0] elapsed;
    logic [2:0] slot;
    r = '0;
    case (it.cmd)
      CMD_ENQUEUE: begin
        lim = (cfg_max_queued < QDEPTH) ? cfg_max_queued : 4'(QDEPTH);
        if (stream_stopped) begin
          r.discarded = 1'b1;
        end else begin
          // backlog spread against the oldest queued unit
          too_long = 1'b0;
          if (fill_level > 0 && it.pts_us != '0) begin
            oldest = slot_pts_mem[head_slot];
            if (oldest != '0 && it.pts_us > oldest)
              too_long = (it.pts_us - oldest) > {24'd0, cfg_max_backlog};
          end
          if (!sync_waiting && (fill_level >= lim || too_long)) begin
            r.flushed_count = fill_level;
            bump_drop_tally(fill_level);
            fill_level = '0;
            sync_waiting = 1'b1;
            wait_drop_cnt = '0;
            wait_since = it.now_us;
          end
          store = 1'b1;
          mark = it.has_idr;
          if (sync_waiting && !it.has_codec_config && !it.has_idr) begin
            elapsed = (it.now_us >= wait_since) ? it.now_us - wait_since : '0;
            expired = wait_drop_cnt >= cfg_sync_drops || elapsed >= {24'd0, cfg_sync_us};
            if (!expired) begin
              bump_drop_tally(1);
              if (wait_drop_cnt < WAIT_DROPS_MAX) wait_drop_cnt = wait_drop_cnt + 1'b1;
              r.discarded = 1'b1;
              store = 1'b0;
            end else if (fill_level >= QDEPTH) begin
              r.discarded = 1'b1;
              store = 1'b0;
            end else begin
              sync_waiting = 1'b0;
              wait_drop_cnt = '0;
              drop_tally = '0;
              mark = 1'b1;
            end
          end else if (fill_level >= QDEPTH) begin
            r.discarded = 1'b1;
            store = 1'b0;
          end
          if (store) begin
            slot = head_slot + fill_level[2:0];
            slot_id_mem[slot] = it.unit_id;
            slot_pts_mem[slot] = it.pts_us;
            fill_level = fill_level + 1'b1;
            r.accepted = 1'b1;
            r.sync_mark = mark;
            if (it.has_idr && sync_waiting) begin
              sync_waiting = 1'b0;
              wait_drop_cnt = '0;
              drop_tally = '0;
            end
          end
        end
      end
      CMD_DEQUEUE: begin
        if (stream_stopped) begin
          r.end_of_stream = 1'b1;
        end else if (fill_level > 0) begin
          r.head_valid = 1'b1;
          r.head_id = slot_id_mem[head_slot];
          head_slot = head_slot + 1'b1;
          fill_level = fill_level - 1'b1;
        end
      end
      CMD_STOP: begin
        if (!stream_stopped) begin
          stream_stopped = 1'b1;
          r.flushed_count = fill_level;
          fill_level = '0;
        end
      end
      default: ;
    endcase
    r.in_sync_wait = sync_waiting;
    r.level = fill_level;
    r.drops_total = drop_tally;
    return r;
  endfunction

  // Send one transaction; the caller is at a rising edge
  task automatic send_item(input item_t it);
    result_t want;
    int gap;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    want = backlog_step(it);
    step_reports.push_back(want);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every result arrive
  task automatic settle();
    start <= 1'b0;
    while (step_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_QUEUED:      cfg_max_queued = value[3:0];
      REG_MAX_BACKLOG_US:  cfg_max_backlog = value;
      REG_SYNC_WAIT_DROPS: cfg_sync_drops = value[3:0];
      REG_SYNC_WAIT_US:    cfg_sync_us = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [3:0] mq, input logic [23:0] mb,
                            input logic [3:0] sd, input logic [23:0] su);
    write_reg(REG_MAX_QUEUED, {20'd0, mq});
    write_reg(REG_MAX_BACKLOG_US, mb);
    write_reg(REG_SYNC_WAIT_DROPS, {20'd0, sd});
    write_reg(REG_SYNC_WAIT_US, su);
  endtask

  function automatic item_t unit(input logic [ID_BITS-1:0] id, input logic [TIME_BITS-1:0] pts,
                                 input logic [TIME_BITS-1:0] now, input logic idr,
                                 input logic cfg);
    item_t it;
    it = '0;
    it.cmd = CMD_ENQUEUE;
    it.unit_id = id;
    it.pts_us = pts;
    it.now_us = now;
    it.has_idr = idr;
    it.has_codec_config = cfg;
    return it;
  endfunction

  function automatic item_t bare_cmd(input logic [1:0] code);
    item_t it;
    it = '0;
    it.cmd = code;
    return it;
  endfunction

  // Random transaction: mostly a well-formed stream, some noise on every field
  function automatic item_t stream_item();
    item_t it;
    logic [63:0] wide;
    int pick;
    it.unit_id = ID_BITS'($urandom);
    wide = {$urandom, $urandom};
    it.pts_us = wide[TIME_BITS-1:0];
    wide = {$urandom, $urandom};
    it.now_us = wide[TIME_BITS-1:0];
    it.has_idr = 1'($urandom);
    it.has_codec_config = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      case ($urandom_range(0, 2))
        0: it.cmd = CMD_ENQUEUE;
        1: it.cmd = CMD_DEQUEUE;
        default: it.cmd = CMD_IDLE;
      endcase
    end else if (pick < 6 + dequeue_pct) begin
      it.cmd = CMD_DEQUEUE;
    end else begin
      it.cmd = CMD_ENQUEUE;
      stream_clock = stream_clock + $urandom_range(frame_step / 2, frame_step);
      it.now_us = stream_clock;
      it.pts_us = ($urandom_range(0, 19) == 0) ? '0 : stream_clock - $urandom_range(0, 1000);
      it.has_idr = $urandom_range(0, 99) < idr_pct;
      it.has_codec_config = $urandom_range(0, 99) < config_pct;
    end
    return it;
  endfunction

  task automatic test_empty_queue();
    send_item(bare_cmd(CMD_DEQUEUE));
    send_item(bare_cmd(CMD_IDLE));
  endtask

  // Occupancy flush, drop in sync-wait, config kept, IDR ends the wait
  task automatic test_occupancy_flush();
    set_config(4'd2, 24'd250000, 4'd8, 24'd250000);
    send_item(unit(8'hFF, 48'd1000, 48'd1000, 1'b0, 1'b0));
    send_item(unit(8'h00, 48'd0, 48'd1100, 1'b0, 1'b0));
    send_item(unit(8'h05, 48'd1200, 48'd1200, 1'b0, 1'b0));
    send_item(unit(8'h06, 48'd1300, 48'd1300, 1'b0, 1'b1));
    send_item(unit(8'h07, 48'd1400, 48'd1400, 1'b1, 1'b0));
    send_item(bare_cmd(CMD_DEQUEUE));
    send_item(bare_cmd(CMD_DEQUEUE));
  endtask

  // Timestamp spread flush with zero spread allowed and zero drop budget
  task automatic test_backlog_flush();
    set_config(4'd8, 24'd0, 4'd0, 24'hFFFFFF);
    send_item(unit(8'h01, 48'd5000, 48'd5000, 1'b0, 1'b0));
    send_item(unit(8'h02, 48'd5001, 48'd5001, 1'b0, 1'b0));
    send_item(unit(8'h03, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0));
  endtask

  // Arrival clock behind the wait start counts as no elapsed time
  task automatic test_clock_behind_wait();
    set_config(4'd0, 24'hFFFFFF, 4'd15, 24'd1);
    send_item(unit(8'h10, 48'd900, 48'd1000, 1'b0, 1'b0));
    send_item(unit(8'h11, 48'd950, 48'd500, 1'b0, 1'b0));
    send_item(unit(8'h12, 48'd1001, 48'd1001, 1'b0, 1'b0));
  endtask

  // Wait ends once the drop budget is used up
  task automatic test_drop_budget();
    set_config(4'd0, 24'hFFFFFF, 4'd2, 24'hFFFFFF);
    send_item(unit(8'h20, 48'd2000, 48'd2000, 1'b0, 1'b0));
    send_item(unit(8'h21, 48'd2001, 48'd2001, 1'b0, 1'b0));
    send_item(unit(8'h22, 48'd2002, 48'd2002, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(4'd8, 24'd250000, 4'd8, 24'd250000);
        1: set_config(4'd1, 24'd0, 4'd0, 24'd0);
        2: set_config(4'd15, 24'hFFFFFF, 4'd15, 24'hFFFFFF);
        default: set_config(4'($urandom_range(0, 15)), 24'($urandom_range(0, 300000)),
                            4'($urandom_range(0, 15)), 24'($urandom_range(0, 300000)));
      endcase
      frame_step = $urandom_range(2, 60000);
      dequeue_pct = $urandom_range(20, 55);
      config_pct = $urandom_range(5, 40);
      idr_pct = $urandom_range(3, 20);
      for (int k = 0; k < 92; k++) begin
        if (k % 23 == 0) gaps_on = (phase != 5) && ($urandom_range(0, 2) != 0);
        send_item(stream_item());
      end
    end
  endtask

  // Stop flushes, then everything is refused
  task automatic test_stop_refusal();
    gaps_on = 1'b0;
    send_item(unit(8'h30, 48'd0, 48'd0, 1'b1, 1'b0));
    send_item(bare_cmd(CMD_STOP));
    send_item(unit(8'h31, 48'd10, 48'd10, 1'b1, 1'b1));
    send_item(bare_cmd(CMD_DEQUEUE));
    send_item(bare_cmd(CMD_STOP));
    send_item(bare_cmd(CMD_IDLE));
  endtask

  task automatic check_field(input string fname, input logic [TIME_BITS-1:0] want,
                             input logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Compare each strobed result with the oldest outstanding transaction
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (step_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, result);
        mismatches++;
      end else begin
        want = step_reports.pop_front();
        check_field("accepted", want.accepted, result.accepted);
        check_field("discarded", want.discarded, result.discarded);
        check_field("sync_mark", want.sync_mark, result.sync_mark);
        check_field("flushed_count", want.flushed_count, result.flushed_count);
        check_field("head_valid", want.head_valid, result.head_valid);
        check_field("head_id", want.head_id, result.head_id);
        check_field("end_of_stream", want.end_of_stream, result.end_of_stream);
        check_field("in_sync_wait", want.in_sync_wait, result.in_sync_wait);
        check_field("level", want.level, result.level);
        check_field("drops_total", want.drops_total, result.drops_total);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    head_slot = '0;
    fill_level = '0;
    sync_waiting = 1'b0;
    wait_drop_cnt = '0;
    wait_since = '0;
    drop_tally = '0;
    stream_stopped = 1'b0;
    cfg_max_queued = MAX_QUEUED_RST;
    cfg_max_backlog = MAX_BACKLOG_US_RST;
    cfg_sync_drops = SYNC_WAIT_DROPS_RST;
    cfg_sync_us = SYNC_WAIT_US_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_occupancy_flush();
    test_backlog_flush();
    test_clock_behind_wait();
    test_drop_budget();
    test_random_traffic();
    test_stop_refusal();
    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/vbdr_pkg.sv
hw/rtl/vbdr_slots.sv
hw/rtl/video_backlog_drop_resync.sv
verif/video_backlog_drop_resync_test.sv
